@@ rtl/x86d_pkg.sv @@
// Types, constants and operation codes shared by the instruction decoder.
package x86d_pkg;

   typedef struct packed {
      logic        code_present;
      logic [63:0] window_low;
      logic [15:0] window_high;
   } req_type;

   typedef struct packed {
      logic [5:0]         op_kind;
      logic [3:0]         inst_length;
      logic [3:0]         dest_reg;
      logic [3:0]         src_reg;
      logic [63:0]        immediate;
      logic signed [31:0] displacement;
      logic               has_immediate;
      logic               has_displacement;
      logic               register_form;
   } rsp_type;

   typedef enum logic [5:0] {
      OP_UNKNOWN = 6'd0,  OP_NOP = 6'd1,   OP_MOV = 6'd2,    OP_PUSH = 6'd3,
      OP_POP = 6'd4,      OP_ADD = 6'd5,   OP_OR = 6'd6,     OP_AND = 6'd7,
      OP_SUB = 6'd8,      OP_XOR = 6'd9,   OP_CMP = 6'd10,   OP_INC = 6'd11,
      OP_DEC = 6'd12,     OP_CALL = 6'd13, OP_JMP = 6'd14,   OP_TEST = 6'd15,
      OP_NOT = 6'd16,     OP_NEG = 6'd17,  OP_IMUL = 6'd18,  OP_STOSD = 6'd19,
      OP_STOSB = 6'd20,   OP_JZ = 6'd21,   OP_JNZ = 6'd22,   OP_JL = 6'd23,
      OP_JGE = 6'd24,     OP_JLE = 6'd25,  OP_JG = 6'd26,    OP_JB = 6'd27,
      OP_JAE = 6'd28,     OP_JBE = 6'd29,  OP_JA = 6'd30,    OP_JS = 6'd31,
      OP_JNS = 6'd32,     OP_LEA = 6'd33,  OP_XCHG = 6'd34,  OP_SHL = 6'd35,
      OP_SHR = 6'd36,     OP_SAR = 6'd37,  OP_CDQ = 6'd38,   OP_RET = 6'd39,
      OP_SYSCALL = 6'd40, OP_MOVZX = 6'd41, OP_MOVSX = 6'd42
   } op_kind_type;

   localparam logic [7:0] REX_LO   = 8'h40;
   localparam logic [7:0] REX_HI   = 8'h4F;
   localparam logic [7:0] MODRM_REG = 8'hC0;

   // classified item passed from front to back
   typedef struct packed {
      logic [3:0]  pos;
      logic        rex_w;
      logic        rex_r;
      logic        rex_b;
      logic [7:0]  op;
      logic [7:0]  m;
      logic [7:0]  b2;
      logic [63:0] tail;
      logic        present;
   } cls_type;

   localparam int QDEPTH = 2;

   function automatic logic [5:0] grp1_kind(input logic [2:0] r);
      case (r)
         3'd0: grp1_kind = OP_ADD;
         3'd1: grp1_kind = OP_OR;
         3'd4: grp1_kind = OP_AND;
         3'd5: grp1_kind = OP_SUB;
         3'd6: grp1_kind = OP_XOR;
         3'd7: grp1_kind = OP_CMP;
         default: grp1_kind = OP_UNKNOWN;
      endcase
   endfunction

   function automatic logic [5:0] shift_kind(input logic [2:0] r);
      case (r)
         3'd4: shift_kind = OP_SHL;
         3'd5: shift_kind = OP_SHR;
         3'd7: shift_kind = OP_SAR;
         default: shift_kind = OP_UNKNOWN;
      endcase
   endfunction

   function automatic logic [5:0] cond_kind(input logic [3:0] c);
      case (c)
         4'h2: cond_kind = OP_JB;
         4'h3: cond_kind = OP_JAE;
         4'h4: cond_kind = OP_JZ;
         4'h5: cond_kind = OP_JNZ;
         4'h6: cond_kind = OP_JBE;
         4'h7: cond_kind = OP_JA;
         4'h8: cond_kind = OP_JS;
         4'h9: cond_kind = OP_JNS;
         4'hC: cond_kind = OP_JL;
         4'hD: cond_kind = OP_JGE;
         4'hE: cond_kind = OP_JLE;
         4'hF: cond_kind = OP_JG;
         default: cond_kind = OP_UNKNOWN;
      endcase
   endfunction

endpackage

@@ rtl/x86d_front.sv @@
// Front stage: strips the REX prefix and registers the classified item.
module x86d_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  x86d_pkg::req_type  req_data,
   output logic               cls_valid,
   input  logic               cls_ready,
   output x86d_pkg::cls_type  cls_data
);
   import x86d_pkg::*;

   logic [79:0] win;
   logic        has_rex;
   cls_type     cls_in;
   cls_type     cls_ff;
   logic        valid_ff;

   assign win     = {req_data.window_high, req_data.window_low};
   assign has_rex = (win[7:0] >= REX_LO) && (win[7:0] <= REX_HI);

   always_comb begin
      cls_in.present = req_data.code_present;
      cls_in.pos     = has_rex ? 4'd1 : 4'd0;
      cls_in.rex_w   = has_rex & win[3];
      cls_in.rex_r   = has_rex & win[2];
      cls_in.rex_b   = has_rex & win[0];
      if (has_rex) begin
         cls_in.op   = win[15:8];
         cls_in.m    = win[23:16];
         cls_in.b2   = win[31:24];
         cls_in.tail = win[79:16];
      end else begin
         cls_in.op   = win[7:0];
         cls_in.m    = win[15:8];
         cls_in.b2   = win[23:16];
         cls_in.tail = win[71:8];
      end
   end

   assign req_ready = !valid_ff || cls_ready;
   assign cls_valid = valid_ff;
   assign cls_data  = cls_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ready) begin
         valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         cls_ff <= cls_in;
      end
   end
endmodule

@@ rtl/x86d_queue.sv @@
// Short FIFO of classified items between front and back.
module x86d_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  x86d_pkg::cls_type  in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output x86d_pkg::cls_type  out_data
);
   import x86d_pkg::*;

   localparam int AW = $clog2(QDEPTH);

   cls_type        mem_ff [QDEPTH];
   logic [AW-1:0]  wr_ff;
   logic [AW-1:0]  rd_ff;
   logic [AW:0]    cnt_ff;
   logic           push;
   logic           pop;

   assign in_ready  = (cnt_ff != (AW+1)'(QDEPTH)) || out_ready;
   assign out_valid = cnt_ff != '0;
   assign out_data  = mem_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= (wr_ff == AW'(QDEPTH - 1)) ? '0 : wr_ff + 1'b1;
         if (pop)  rd_ff <= (rd_ff == AW'(QDEPTH - 1)) ? '0 : rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
      end
      if (push) begin
         mem_ff[wr_ff] <= in_data;
      end
   end
endmodule

@@ rtl/x86d_back.sv @@
// Back stage: decodes opcode forms and registers the result item.
module x86d_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               cls_valid,
   output logic               cls_ready,
   input  x86d_pkg::cls_type  cls_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output x86d_pkg::rsp_type  rsp_data
);
   import x86d_pkg::*;

   rsp_type     d;
   rsp_type     rsp_ff;
   logic        valid_ff;
   logic [7:0]  op;
   logic [7:0]  m;
   logic [7:0]  m2;
   logic [3:0]  pos;
   logic [3:0]  rm;
   logic [3:0]  rg;
   logic [3:0]  rm2;
   logic [3:0]  rg2;
   logic [2:0]  regop;
   logic        mreg;
   logic        m2reg;
   logic [63:0] t;
   logic [31:0] imm32_a;
   logic [31:0] imm32_b;

   assign op      = cls_data.op;
   assign m       = cls_data.m;
   assign m2      = cls_data.b2;
   assign pos     = cls_data.pos;
   assign t       = cls_data.tail;
   assign rm      = {cls_data.rex_b, m[2:0]};
   assign rg      = {cls_data.rex_r, m[5:3]};
   assign rm2     = {cls_data.rex_b, m2[2:0]};
   assign rg2     = {cls_data.rex_r, m2[5:3]};
   assign regop   = m[5:3];
   assign mreg    = m >= MODRM_REG;
   assign m2reg   = m2 >= MODRM_REG;
   // t holds bytes starting at opcode+1
   assign imm32_a = t[31:0];
   assign imm32_b = t[39:8];

   always_comb begin
      d = '0;
      if (cls_data.present) begin
         if (op >= 8'hB8) begin
            if (op <= 8'hBF) begin
               d.op_kind = OP_MOV;
               d.dest_reg = {cls_data.rex_b, op[2:0]};
               d.has_immediate = 1'b1;
               if (cls_data.rex_w) begin
                  d.immediate = t;
                  d.inst_length = pos + 4'd9;
               end else begin
                  d.immediate = {32'd0, imm32_a};
                  d.inst_length = pos + 4'd5;
               end
            end
         end
         if (op >= 8'hB0 && op <= 8'hB7) begin
            d.op_kind = OP_MOV; d.dest_reg = {cls_data.rex_b, op[2:0]};
            d.immediate = {56'd0, m}; d.has_immediate = 1'b1; d.inst_length = pos + 4'd2;
         end else if (op >= 8'h50 && op <= 8'h5F) begin
            d.op_kind = op[3] ? OP_POP : OP_PUSH;
            d.dest_reg = {cls_data.rex_b, op[2:0]}; d.inst_length = pos + 4'd1;
         end else if (op >= 8'h70 && op <= 8'h7F) begin
            d.op_kind = cond_kind(op[3:0]);
            if (d.op_kind != OP_UNKNOWN) begin
               d.displacement = 32'(signed'(m)); d.has_displacement = 1'b1;
               d.inst_length = pos + 4'd2;
            end else begin
               d.inst_length = pos + 4'd1;
            end
         end else if (op >= 8'h91 && op <= 8'h97) begin
            d.op_kind = OP_XCHG; d.src_reg = {cls_data.rex_b, op[2:0]};
            d.register_form = 1'b1; d.inst_length = pos + 4'd1;
         end else if (op < 8'hB8 || op > 8'hBF) begin
            case (op)
               8'h90: begin d.op_kind = OP_NOP; d.inst_length = pos + 4'd1; end
               8'hC7: begin
                  if (mreg) begin
                     d.op_kind = OP_MOV; d.dest_reg = rm; d.immediate = {32'd0, imm32_b};
                     d.has_immediate = 1'b1; d.inst_length = pos + 4'd6;
                  end
               end
               8'h81: begin
                  d.op_kind = grp1_kind(regop); d.dest_reg = rm;
                  d.immediate = {32'd0, imm32_b}; d.has_immediate = 1'b1;
                  d.inst_length = pos + 4'd6;
               end
               8'h83: begin
                  d.op_kind = grp1_kind(regop); d.dest_reg = rm;
                  d.immediate = 64'(signed'(m2)); d.has_immediate = 1'b1;
                  d.inst_length = pos + 4'd3;
               end
               8'hFF: begin
                  d.dest_reg = rm; d.inst_length = pos + 4'd2;
                  case (regop)
                     3'd0: d.op_kind = OP_INC;
                     3'd1: d.op_kind = OP_DEC;
                     3'd2: begin d.op_kind = OP_CALL; d.register_form = mreg; end
                     3'd4: begin d.op_kind = OP_JMP; d.register_form = mreg; end
                     3'd6: d.op_kind = OP_PUSH;
                     default: d.op_kind = OP_UNKNOWN;
                  endcase
               end
               8'hF7: begin
                  d.dest_reg = rm; d.inst_length = pos + 4'd2;
                  case (regop)
                     3'd0: begin
                        d.op_kind = OP_TEST; d.immediate = {32'd0, imm32_b};
                        d.has_immediate = 1'b1; d.inst_length = pos + 4'd6;
                     end
                     3'd2: d.op_kind = OP_NOT;
                     3'd3: d.op_kind = OP_NEG;
                     3'd5: d.op_kind = OP_IMUL;
                     default: d.op_kind = OP_UNKNOWN;
                  endcase
               end
               8'hAB: begin d.op_kind = OP_STOSD; d.inst_length = pos + 4'd1; end
               8'hAA: begin d.op_kind = OP_STOSB; d.inst_length = pos + 4'd1; end
               8'hEB: begin
                  d.op_kind = OP_JMP; d.displacement = 32'(signed'(m));
                  d.has_displacement = 1'b1; d.inst_length = pos + 4'd2;
               end
               8'hE9: begin
                  d.op_kind = OP_JMP; d.displacement = imm32_a;
                  d.has_displacement = 1'b1; d.inst_length = pos + 4'd5;
               end
               8'h01, 8'h03, 8'h29, 8'h2B, 8'h39, 8'h3B, 8'h21, 8'h23,
               8'h09, 8'h0B, 8'h31, 8'h33, 8'h85, 8'h89, 8'h8B, 8'h87,
               8'h6B, 8'h69: begin
                  if (mreg) begin
                     d.register_form = 1'b1;
                     d.inst_length = pos + 4'd2;
                     case (op)
                        8'h01, 8'h03: d.op_kind = OP_ADD;
                        8'h29, 8'h2B: d.op_kind = OP_SUB;
                        8'h39, 8'h3B: d.op_kind = OP_CMP;
                        8'h21, 8'h23: d.op_kind = OP_AND;
                        8'h09, 8'h0B: d.op_kind = OP_OR;
                        8'h31, 8'h33: d.op_kind = OP_XOR;
                        8'h85: d.op_kind = OP_TEST;
                        8'h87: d.op_kind = OP_XCHG;
                        8'h6B, 8'h69: d.op_kind = OP_IMUL;
                        default: d.op_kind = OP_MOV;
                     endcase
                     if ((op[1] && op != 8'h87) || op == 8'h69) begin
                        d.dest_reg = rg; d.src_reg = rm;
                     end else begin
                        d.dest_reg = rm; d.src_reg = rg;
                     end
                     if (op == 8'h6B) begin
                        d.immediate = 64'(signed'(m2)); d.has_immediate = 1'b1;
                        d.inst_length = pos + 4'd3;
                     end else if (op == 8'h69) begin
                        d.immediate = 64'(signed'(imm32_b)); d.has_immediate = 1'b1;
                        d.inst_length = pos + 4'd6;
                     end
                  end
               end
               8'h8D: begin
                  d.op_kind = OP_LEA; d.dest_reg = rg; d.inst_length = pos + 4'd2;
                  if (m[7:6] == 2'd0 && m[2:0] == 3'd5) begin
                     d.displacement = imm32_b; d.has_displacement = 1'b1;
                     d.inst_length = pos + 4'd6;
                  end else if (m[7:6] == 2'd1) begin
                     d.src_reg = rm; d.displacement = 32'(signed'(m2));
                     d.has_displacement = 1'b1; d.register_form = 1'b1;
                     d.inst_length = pos + 4'd3;
                  end else if (m[7:6] == 2'd2) begin
                     d.src_reg = rm; d.displacement = imm32_b;
                     d.has_displacement = 1'b1; d.register_form = 1'b1;
                     d.inst_length = pos + 4'd6;
                  end else if (m[7:6] == 2'd3) begin
                     d.src_reg = rm; d.register_form = 1'b1;
                  end
               end
               8'hC1: begin
                  d.op_kind = shift_kind(regop); d.dest_reg = rm;
                  d.immediate = {56'd0, m2}; d.has_immediate = 1'b1;
                  d.inst_length = pos + 4'd3;
               end
               8'hD1: begin
                  d.op_kind = shift_kind(regop); d.dest_reg = rm;
                  d.immediate = 64'd1; d.has_immediate = 1'b1;
                  d.inst_length = pos + 4'd2;
               end
               8'h99: begin d.op_kind = OP_CDQ; d.inst_length = pos + 4'd1; end
               8'hC3: begin d.op_kind = OP_RET; d.inst_length = pos + 4'd1; end
               8'hC2: begin
                  d.op_kind = OP_RET; d.immediate = {48'd0, t[15:0]};
                  d.has_immediate = 1'b1; d.inst_length = pos + 4'd3;
               end
               8'hE8: begin
                  d.op_kind = OP_CALL; d.immediate = 64'(signed'(imm32_a));
                  d.has_immediate = 1'b1; d.inst_length = pos + 4'd5;
               end
               8'h0F: begin
                  if (m == 8'h05) begin
                     d.op_kind = OP_SYSCALL; d.inst_length = pos + 4'd2;
                  end else if (m == 8'hAF || m == 8'hB6 || m == 8'hB7 ||
                               m == 8'hBE || m == 8'hBF) begin
                     if (m2reg) begin
                        d.register_form = 1'b1; d.dest_reg = rg2; d.src_reg = rm2;
                        d.inst_length = pos + 4'd3;
                        if (m == 8'hAF) d.op_kind = OP_IMUL;
                        else d.op_kind = (m < 8'hB8) ? OP_MOVZX : OP_MOVSX;
                        if (m != 8'hAF && m[0]) begin
                           d.immediate = 64'd16; d.has_immediate = 1'b1;
                        end
                     end
                  end else if (m[7:4] == 4'h8 && cond_kind(m[3:0]) != OP_UNKNOWN) begin
                     d.op_kind = cond_kind(m[3:0]); d.displacement = imm32_b;
                     d.has_displacement = 1'b1; d.inst_length = pos + 4'd6;
                  end else begin
                     d.inst_length = pos + 4'd2;
                  end
               end
               default: d.inst_length = pos + 4'd1;
            endcase
         end
      end
   end

   assign cls_ready = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cls_ready) begin
         valid_ff <= cls_valid;
      end
      if (cls_valid && cls_ready) begin
         rsp_ff <= d;
      end
   end
endmodule

@@ rtl/x86_64_instruction_decoder.sv @@
// Top level of the x86-64 subset instruction decoder.
// Decodes one instruction from a 10-byte window per item. One item is accepted
// every cycle while the result side does not stall; each result passes through the front
// register, the two-entry queue and the result register, and either side may stall freely.
module x86_64_instruction_decoder (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  x86d_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output x86d_pkg::rsp_type  rsp_data
);
   import x86d_pkg::*;

   logic    f_valid, f_ready, b_valid, b_ready;
   cls_type f_data, b_data;

   x86d_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .cls_valid(f_valid), .cls_ready(f_ready), .cls_data(f_data)
   );

   x86d_queue u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
      .out_valid(b_valid), .out_ready(b_ready), .out_data(b_data)
   );

   x86d_back u_back (
      .clock, .reset,
      .cls_valid(b_valid), .cls_ready(b_ready), .cls_data(b_data),
      .rsp_valid, .rsp_ready, .rsp_data
   );

`ifndef NO_ASSERTIONS
   a_len_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.inst_length <= 4'd10)
      else $error("length out of range");
   a_unknown_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.inst_length == 4'd0 |->
      rsp_data.op_kind == OP_UNKNOWN && !rsp_data.has_immediate)
      else $error("rejected item carries fields");
   a_absent: assert property (@(posedge clock) disable iff (reset)
      b_valid && b_ready && !b_data.present |=> rsp_data.inst_length == 4'd0)
      else $error("absent window decoded");
`endif
endmodule
